// File: src/imufp_pkg.sv
// ----------------------------------------------------------------------------
// imufp_pkg
// Shared codes, widths and the reading scaler of the inertial sensor frame
// parser.
// ----------------------------------------------------------------------------
package imufp_pkg;

  // input commands
  localparam logic [1:0] CMD_BYTE     = 2'd0;
  localparam logic [1:0] CMD_TICK     = 2'd1;
  localparam logic [1:0] CMD_LINK_ERR = 2'd2;

  // frame kinds reported with each result
  localparam logic [2:0] KIND_NONE  = 3'd0;
  localparam logic [2:0] KIND_ACCEL = 3'd1;
  localparam logic [2:0] KIND_GYRO  = 3'd2;
  localparam logic [2:0] KIND_ANGLE = 3'd3;
  localparam logic [2:0] KIND_OTHER = 3'd4;

  // link status codes
  localparam logic [1:0] LINK_NOT_READY = 2'd0;
  localparam logic [1:0] LINK_OK        = 2'd1;
  localparam logic [1:0] LINK_CSUM_ERR  = 2'd2;
  localparam logic [1:0] LINK_ERR       = 2'd3;

  // frame bytes
  localparam logic [7:0] HDR_BYTE = 8'h55;
  localparam logic [7:0] TYPE_ACC = 8'h51;
  localparam logic [7:0] TYPE_GYR = 8'h52;
  localparam logic [7:0] TYPE_ANG = 8'h53;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_RANGE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_RANGE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_RANGE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 3'd3;

  localparam int unsigned RANGE_W   = 12;
  localparam int unsigned TIMEOUT_W = 16;
  localparam int unsigned RAW_W     = 16;
  localparam int unsigned VALUE_W   = 28;
  localparam int unsigned NUM_VEC   = 3;

  localparam int unsigned WIN_LEN = 10;
  localparam int unsigned FILL_W  = 4;

  localparam logic [RANGE_W-1:0]   ACCEL_RANGE_RST = 12'd16;
  localparam logic [RANGE_W-1:0]   GYRO_RANGE_RST  = 12'd2000;
  localparam logic [RANGE_W-1:0]   ANGLE_RANGE_RST = 12'd180;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST     = 16'd500;

  typedef logic [7:0] byte_t;

  // little-endian signed reading times unsigned range, 15 fraction bits
  function automatic logic signed [VALUE_W-1:0] scale_reading(
    input byte_t               lo,
    input byte_t               hi,
    input logic [RANGE_W-1:0]  range
  );
    logic signed [RAW_W-1:0]         raw;
    logic signed [RANGE_W:0]         rng;
    logic signed [RAW_W+RANGE_W:0]   prod;
    raw  = $signed({hi, lo});
    rng  = $signed({1'b0, range});
    prod = raw * rng;
    return prod[VALUE_W-1:0];
  endfunction

endpackage

// File: src/imu_frame_parser_with_staleness.sv
// ----------------------------------------------------------------------------
// imu_frame_parser_with_staleness
// Serial frame parser for an inertial sensor with per-vector staleness marks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one command per transfer:
//   a received byte, a staleness tick or a link error. Every transfer yields
//   exactly one result on the output channel (out_valid_o / out_stall_i):
//   frame kind, three scaled readings, link status and the three fresh marks.
//   A result passes through the input register, then the result register,
//   before it is presented. Throughput: one transfer per cycle while the
//   output is not stalled. The result stage holds the ten-byte checksum
//   adder tree and three 16x12 multipliers; nothing iterates.
//   A stalled result stays in the result register while the input register
//   keeps one more item; input stall rises only when both are occupied.
//   Reset empties the byte window, clears all fresh marks and stamps, sets the
//   link status to ok and loads the default range and timeout registers.
//   Registers are written through cfg_we_i / cfg_index_i / cfg_wdata_i and
//   take effect on the next item; indexes beyond the list are ignored.
// ----------------------------------------------------------------------------
module imu_frame_parser_with_staleness import imufp_pkg::*; #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata_i,
  // input channel
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                command_i,
  input  logic [7:0]                rx_byte_i,
  input  logic [31:0]               now_ms_i,
  // output channel
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [2:0]                frame_kind_o,
  output logic signed [VALUE_W-1:0] value_x_o,
  output logic signed [VALUE_W-1:0] value_y_o,
  output logic signed [VALUE_W-1:0] value_z_o,
  output logic [1:0]                link_state_o,
  output logic                      accel_valid_o,
  output logic                      gyro_valid_o,
  output logic                      angle_valid_o
);

  // configuration registers
  logic [RANGE_W-1:0]   accel_range_q, gyro_range_q, angle_range_q;
  logic [TIMEOUT_W-1:0] timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_range_q <= ACCEL_RANGE_RST;
      gyro_range_q  <= GYRO_RANGE_RST;
      angle_range_q <= ANGLE_RANGE_RST;
      timeout_q     <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_ACCEL_RANGE: accel_range_q <= cfg_wdata_i[RANGE_W-1:0];
        REG_GYRO_RANGE:  gyro_range_q  <= cfg_wdata_i[RANGE_W-1:0];
        REG_ANGLE_RANGE: angle_range_q <= cfg_wdata_i[RANGE_W-1:0];
        REG_TIMEOUT:     timeout_q     <= cfg_wdata_i[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic                 s1_valid_q;
  logic [1:0]           cmd_q;
  byte_t                byte_q;
  logic [TIME_BITS-1:0] now_q;

  logic advance;
  logic fire;

  assign advance    = !out_valid_o || !out_stall_i;
  assign fire       = s1_valid_q && advance;
  assign in_stall_o = s1_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      cmd_q  <= command_i;
      byte_q <= rx_byte_i;
      now_q  <= TIME_BITS'(now_ms_i);
    end
  end

  // parser state
  byte_t                win_q [WIN_LEN];
  byte_t                win_d [WIN_LEN];
  logic [FILL_W-1:0]    fill_q, fill_d;
  logic [NUM_VEC-1:0]   fresh_q, fresh_d;
  logic [TIME_BITS-1:0] stamp_q [NUM_VEC];
  logic [TIME_BITS-1:0] stamp_d [NUM_VEC];
  logic [1:0]           status_q, status_d;

  // checksum over the full window as a small adder tree
  byte_t pair_sum [WIN_LEN/2];
  byte_t win_sum;

  always_comb begin
    for (int i = 0; i < WIN_LEN/2; i++) begin
      pair_sum[i] = win_q[2*i] + win_q[2*i+1];
    end
  end

  assign win_sum = pair_sum[0] + pair_sum[1] + pair_sum[2] + pair_sum[3] + pair_sum[4];

  logic win_full;
  logic hdr_here;
  logic csum_ok;

  assign win_full = (fill_q == FILL_W'(WIN_LEN));
  assign hdr_here = win_full && (win_q[0] == HDR_BYTE);
  assign csum_ok  = (win_sum == byte_q);

  // staleness ages
  logic [NUM_VEC-1:0] too_old;

  always_comb begin
    for (int i = 0; i < NUM_VEC; i++) begin
      too_old[i] = (now_q - stamp_q[i]) > TIME_BITS'(timeout_q);
    end
  end

  logic [2:0]                kind;
  logic signed [VALUE_W-1:0] vx, vy, vz;
  logic [RANGE_W-1:0]        sel_range;

  always_comb begin
    case (win_q[1])
      TYPE_ACC: sel_range = accel_range_q;
      TYPE_GYR: sel_range = gyro_range_q;
      TYPE_ANG: sel_range = angle_range_q;
      default:  sel_range = '0;
    endcase
  end

  always_comb begin
    win_d    = win_q;
    fill_d   = fill_q;
    fresh_d  = fresh_q;
    stamp_d  = stamp_q;
    status_d = status_q;
    kind     = KIND_NONE;
    vx       = '0;
    vy       = '0;
    vz       = '0;
    if (fire) begin
      case (cmd_q)
        CMD_BYTE: begin
          if (hdr_here && csum_ok) begin
            // whole frame consumed
            fill_d   = '0;
            status_d = LINK_OK;
            case (win_q[1])
              TYPE_ACC: kind = KIND_ACCEL;
              TYPE_GYR: kind = KIND_GYRO;
              TYPE_ANG: kind = KIND_ANGLE;
              default:  kind = KIND_OTHER;
            endcase
            if (kind != KIND_OTHER) begin
              vx = scale_reading(win_q[2], win_q[3], sel_range);
              vy = scale_reading(win_q[4], win_q[5], sel_range);
              vz = scale_reading(win_q[6], win_q[7], sel_range);
              fresh_d[kind[1:0] - 2'd1] = 1'b1;
              stamp_d[kind[1:0] - 2'd1] = now_q;
            end
          end else begin
            if (hdr_here) begin
              status_d = LINK_CSUM_ERR;
            end
            if (win_full) begin
              // drop the oldest byte, resync one position later
              for (int i = 0; i < WIN_LEN - 1; i++) begin
                win_d[i] = win_q[i+1];
              end
              win_d[WIN_LEN-1] = byte_q;
            end else begin
              win_d[fill_q] = byte_q;
              fill_d        = fill_q + FILL_W'(1);
            end
          end
        end
        CMD_TICK: begin
          for (int i = 0; i < NUM_VEC; i++) begin
            if (fresh_q[i] && too_old[i]) begin
              fresh_d[i] = 1'b0;
            end
          end
        end
        CMD_LINK_ERR: begin
          fill_d   = '0;
          status_d = LINK_ERR;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      fresh_q  <= '0;
      status_q <= LINK_OK;
      for (int i = 0; i < NUM_VEC; i++) begin
        stamp_q[i] <= '0;
      end
    end else begin
      fill_q   <= fill_d;
      fresh_q  <= fresh_d;
      status_q <= status_d;
      stamp_q  <= stamp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  // result register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      frame_kind_o  <= kind;
      value_x_o     <= vx;
      value_y_o     <= vy;
      value_z_o     <= vz;
      link_state_o  <= status_d;
      accel_valid_o <= fresh_d[0];
      gyro_valid_o  <= fresh_d[1];
      angle_valid_o <= fresh_d[2];
    end
  end

  assign out_valid_o = out_valid_q;

  // checks
  a_frame_means_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_kind_o != KIND_NONE |-> link_state_o == LINK_OK)
    else $error("frame reported without ok link status");

  a_accel_marks_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_kind_o == KIND_ACCEL |-> accel_valid_o)
    else $error("accel frame did not mark its vector fresh");

  a_values_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (frame_kind_o == KIND_NONE || frame_kind_o == KIND_OTHER)
    |-> value_x_o == '0 && value_y_o == '0 && value_z_o == '0)
    else $error("nonzero readings without a vector frame");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while result register can drain");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(WIN_LEN))
    else $error("byte window fill beyond its depth");

endmodule
